/* design/websocket_frame_deframer_defines.svh */
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* design/wsd_pkg.sv */
package wsd_pkg;

    localparam int MASK_KEY_BYTES = 4;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [3:0] LEN16_BYTES = 4'd2;
    localparam logic [3:0] LEN64_BYTES = 4'd8;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_EMPTY    = 3'd1,
        KIND_UNMASKED = 3'd2,
        KIND_BAD_OP   = 3'd3,
        KIND_ORPHAN   = 3'd4
    } t_kind;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_KEY  = 6'b001000,
        PH_PAY  = 6'b010000,
        PH_HALT = 6'b100000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [3:0] frame_opcode;
        logic       is_binary;
        logic       frame_end;
        logic       message_end;
        logic       stopped;
    } t_result;

endpackage

/* design/wsd_parser.sv */
module wsd_parser #(
    parameter int MASK_KEY_BYTES = wsd_pkg::MASK_KEY_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_server_mode,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);

    localparam int POS_W = (MASK_KEY_BYTES > 1) ? $clog2(MASK_KEY_BYTES) : 1;

    wsd_pkg::t_phase                   r_phase, n_phase;
    logic [3:0]                        r_cnt, n_cnt;
    logic [3:0]                        r_opcode, n_opcode;
    logic                              r_fin, n_fin;
    logic                              r_masked, n_masked;
    logic                              r_orphan, n_orphan;
    logic [MASK_KEY_BYTES-1:0][7:0]    r_key, n_key;
    logic [63:0]                       r_len, n_len;
    logic [POS_W-1:0]                  r_pos, n_pos;
    logic                              r_frag_open, n_frag_open;
    logic                              r_frag_binary, n_frag_binary;

    logic [6:0]       len7;
    logic             kop_go;
    logic             bp_go;
    logic             fe_go;
    wsd_pkg::t_kind   fe_kind;
    logic [7:0]       fe_data;
    logic [7:0]       key_byte;
    logic             last;
    logic             op_ok;
    logic             fr_binary;
    logic             fr_data;
    logic             halt_now;
    wsd_pkg::t_result res;
    logic             res_valid;

    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_opcode      = r_opcode;
        n_fin         = r_fin;
        n_masked      = r_masked;
        n_orphan      = r_orphan;
        n_key         = r_key;
        n_len         = r_len;
        n_pos         = r_pos;
        n_frag_open   = r_frag_open;
        n_frag_binary = r_frag_binary;
        len7          = i_byte[6:0];
        kop_go        = 1'b0;
        bp_go         = 1'b0;
        fe_go         = 1'b0;
        fe_kind       = wsd_pkg::KIND_EMPTY;
        fe_data       = 8'd0;
        last          = (r_len == 64'd1);
        key_byte      = r_masked ? r_key[POS_W'(MASK_KEY_BYTES - 1) - r_pos] : 8'd0;
        op_ok         = (r_opcode == wsd_pkg::OP_CONT) || (r_opcode == wsd_pkg::OP_TEXT)
                     || (r_opcode == wsd_pkg::OP_BINARY) || (r_opcode == wsd_pkg::OP_CLOSE)
                     || (r_opcode == wsd_pkg::OP_PING) || (r_opcode == wsd_pkg::OP_PONG);
        res_valid     = 1'b0;
        res           = '{kind: wsd_pkg::KIND_PAYLOAD, data: 8'd0, frame_opcode: r_opcode,
                          is_binary: 1'b0, frame_end: 1'b0, message_end: 1'b0,
                          stopped: 1'b0};

        if (i_step) begin
            unique case (r_phase)
                wsd_pkg::PH_HDR0: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_orphan = 1'b0;
                    n_phase  = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1: begin
                    if (i_server_mode && !i_byte[7]) begin
                        res_valid   = 1'b1;
                        res.kind    = wsd_pkg::KIND_UNMASKED;
                        res.stopped = 1'b1;
                        n_phase     = wsd_pkg::PH_HALT;
                    end else if (!op_ok) begin
                        res_valid   = 1'b1;
                        res.kind    = wsd_pkg::KIND_BAD_OP;
                        res.stopped = 1'b1;
                        n_phase     = wsd_pkg::PH_HALT;
                    end else begin
                        n_masked = i_server_mode;
                        if (len7 == wsd_pkg::LEN16_CODE || len7 == wsd_pkg::LEN64_CODE) begin
                            n_len   = '0;
                            n_cnt   = (len7 == wsd_pkg::LEN16_CODE) ? wsd_pkg::LEN16_BYTES
                                                                     : wsd_pkg::LEN64_BYTES;
                            n_phase = wsd_pkg::PH_EXT;
                        end else begin
                            n_len  = 64'(len7);
                            kop_go = 1'b1;
                        end
                    end
                end
                wsd_pkg::PH_EXT: begin
                    n_len = {r_len[55:0], i_byte};
                    n_cnt = r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        kop_go = 1'b1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_key = {r_key[MASK_KEY_BYTES-2:0], i_byte};
                    n_cnt = r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        bp_go = 1'b1;
                    end
                end
                wsd_pkg::PH_PAY: begin
                    n_len = r_len - 64'd1;
                    n_pos = (r_pos == POS_W'(MASK_KEY_BYTES - 1)) ? '0 : r_pos + POS_W'(1);
                    if (last) begin
                        fe_go   = 1'b1;
                        fe_kind = r_orphan ? wsd_pkg::KIND_ORPHAN : wsd_pkg::KIND_PAYLOAD;
                        fe_data = r_orphan ? 8'd0 : (i_byte ^ key_byte);
                    end else if (!r_orphan) begin
                        res_valid     = 1'b1;
                        res.data      = i_byte ^ key_byte;
                        res.is_binary = (r_opcode == wsd_pkg::OP_BINARY)
                                     || (r_opcode == wsd_pkg::OP_CONT && r_frag_binary);
                    end
                end
                wsd_pkg::PH_HALT: begin
                    // drop everything until reset
                end
                default: begin
                    n_phase = wsd_pkg::PH_HDR0;
                end
            endcase
        end

        // mask key next, or straight on to the payload or an empty frame's end
        if (kop_go) begin
            if (n_masked) begin
                n_cnt   = 4'(MASK_KEY_BYTES);
                n_phase = wsd_pkg::PH_KEY;
            end else begin
                bp_go = 1'b1;
            end
        end

        if (bp_go) begin
            n_orphan = 1'b0;
            if (r_opcode == wsd_pkg::OP_TEXT || r_opcode == wsd_pkg::OP_BINARY) begin
                n_frag_open = !r_fin;
                if (!r_fin) begin
                    n_frag_binary = (r_opcode == wsd_pkg::OP_BINARY);
                end
            end else if (r_opcode == wsd_pkg::OP_CONT) begin
                if (!r_frag_open) begin
                    n_orphan = 1'b1;
                end else if (r_fin) begin
                    n_frag_open = 1'b0;
                end
            end
            n_pos = '0;
            if (n_len == 64'd0) begin
                fe_go   = 1'b1;
                fe_kind = n_orphan ? wsd_pkg::KIND_ORPHAN : wsd_pkg::KIND_EMPTY;
            end else begin
                n_phase = wsd_pkg::PH_PAY;
            end
        end

        fr_binary = (r_opcode == wsd_pkg::OP_BINARY)
                 || (r_opcode == wsd_pkg::OP_CONT && !n_orphan && r_frag_binary);
        fr_data   = (r_opcode == wsd_pkg::OP_TEXT) || (r_opcode == wsd_pkg::OP_BINARY)
                 || (r_opcode == wsd_pkg::OP_CONT && !n_orphan);
        halt_now  = (r_opcode == wsd_pkg::OP_CLOSE);

        // last result of the frame: back to header, or halt after a close
        if (fe_go) begin
            res_valid       = 1'b1;
            res.kind        = fe_kind;
            res.data        = fe_data;
            res.is_binary   = fr_binary;
            res.frame_end   = 1'b1;
            res.message_end = r_fin && fr_data;
            res.stopped     = halt_now;
            n_phase         = halt_now ? wsd_pkg::PH_HALT : wsd_pkg::PH_HDR0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= wsd_pkg::PH_HDR0;
            r_cnt         <= '0;
            r_opcode      <= '0;
            r_fin         <= 1'b1;
            r_masked      <= 1'b0;
            r_orphan      <= 1'b0;
            r_len         <= '0;
            r_pos         <= '0;
            r_frag_open   <= 1'b0;
            r_frag_binary <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_opcode      <= n_opcode;
            r_fin         <= n_fin;
            r_masked      <= n_masked;
            r_orphan      <= n_orphan;
            r_len         <= n_len;
            r_pos         <= n_pos;
            r_frag_open   <= n_frag_open;
            r_frag_binary <= n_frag_binary;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

endmodule

/* design/websocket_frame_deframer.sv */
// An accepted byte is registered at the input, and its result at the output register.
// Throughput: one byte per cycle unless the output stalls; header, key and payload
// bytes each take one pass through the parser between the input and output registers.
// Reset (synchronous, active low) returns to the first header byte, clears the
// fragment state and the halt, and sets server mode; the mask key is not reset.
module websocket_frame_deframer #(
    parameter int MASK_KEY_BYTES = wsd_pkg::MASK_KEY_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_data,
    output logic [3:0] o_frame_opcode,
    output logic       o_is_binary,
    output logic       o_frame_end,
    output logic       o_message_end,
    output logic       o_stopped,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_server_mode
);

    logic             r_server_mode;
    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid, n_out_valid;
    wsd_pkg::t_result r_out;

    logic             out_blocked;
    logic             step;
    logic             in_accept;
    logic             res_valid;
    wsd_pkg::t_result res;

    assign out_blocked = r_out_valid && i_stall;
    assign step        = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    wsd_parser #(
        .MASK_KEY_BYTES(MASK_KEY_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_server_mode(r_server_mode),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = res_valid;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_mode <= 1'b1;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_server_mode <= i_cfg_server_mode;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the beats while stalled; load the input on accept, the output on a pass with a result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data         = r_out.data;
    assign o_frame_opcode = r_out.frame_opcode;
    assign o_is_binary    = r_out.is_binary;
    assign o_frame_end    = r_out.frame_end;
    assign o_message_end  = r_out.message_end;
    assign o_stopped      = r_out.stopped;

endmodule

/* design/wsd_checker.sv */
`include "websocket_frame_deframer_defines.svh"

module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_kind,
    input logic [7:0] o_data,
    input logic       o_frame_end,
    input logic       o_stopped
);

    // a stalled result beat holds
    `WSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data) && $stable(o_kind))

    // header errors halt and do not end a frame
    `WSD_ASSERT_NOW(a_err_halts, i_clk, i_rst_n, o_valid && (o_kind == wsd_pkg::KIND_UNMASKED || o_kind == wsd_pkg::KIND_BAD_OP), o_stopped && !o_frame_end)

    // nothing follows a halting beat once it is taken
    `WSD_ASSERT_NEXT(a_halt_quiet, i_clk, i_rst_n, o_valid && o_stopped && !i_stall, !o_valid)

    // data is zero on all but payload beats
    `WSD_ASSERT_NOW(a_data_zero, i_clk, i_rst_n, o_valid && o_kind != wsd_pkg::KIND_PAYLOAD, o_data == 8'd0)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_kind     (o_kind),
    .o_data     (o_data),
    .o_frame_end(o_frame_end),
    .o_stopped  (o_stopped)
);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_PCT     = 26;
    localparam int SETTLE_CYC   = 4;
    localparam int TAIL_CYC     = 12;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_BYTES  = 135;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_PRINTS   = 40;
    localparam int NUM_DIRECTED = 27;

    typedef struct {
        logic [7:0]       rx;
        bit               typed;
        wsd_pkg::t_result want;
    } t_row;

    localparam wsd_pkg::t_result NO_RESULT = '0;
    localparam wsd_pkg::t_result WANT_EMPTY_TEXT = '{kind: wsd_pkg::KIND_EMPTY,
        data: 8'h00, frame_opcode: wsd_pkg::OP_TEXT, is_binary: 1'b0, frame_end: 1'b1,
        message_end: 1'b1, stopped: 1'b0};
    localparam wsd_pkg::t_result WANT_ORPHAN = '{kind: wsd_pkg::KIND_ORPHAN,
        data: 8'h00, frame_opcode: wsd_pkg::OP_CONT, is_binary: 1'b0, frame_end: 1'b1,
        message_end: 1'b0, stopped: 1'b0};

    // Server mode throughout: text FIN empty, binary fragment of one byte,
    // continuation closing it through a 16-bit zero length, then an orphan.
    t_row directed_rows [NUM_DIRECTED] = '{
        '{8'h81, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b1, WANT_EMPTY_TEXT},
        '{8'h02, 1'b0, NO_RESULT}, '{8'h81, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, NO_RESULT}, '{8'h5A, 1'b0, NO_RESULT},
        '{8'hC3, 1'b0, NO_RESULT}, '{8'h3C, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT}, '{8'hFE, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, NO_RESULT}, '{8'h34, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, NO_RESULT}, '{8'h78, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
        '{8'h9A, 1'b0, NO_RESULT}, '{8'hBC, 1'b0, NO_RESULT},
        '{8'hDE, 1'b0, NO_RESULT}, '{8'hF0, 1'b1, WANT_ORPHAN}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_kind;
    logic [7:0] o_data;
    logic [3:0] o_frame_opcode;
    logic       o_is_binary;
    logic       o_frame_end;
    logic       o_message_end;
    logic       o_stopped;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_server_mode = 1'b0;

    // Tag riding along with the beat on the input channel.
    bit               row_typed = 1'b0;
    wsd_pkg::t_result row_want = '0;

    bit               steady = 1'b0;
    bit               mode_now = 1'b1;
    int unsigned      bytes_taken = 0;
    int unsigned      cfg_taken = 0;
    int unsigned      results_seen = 0;
    int unsigned      mismatches = 0;
    int unsigned      quiet_cycles = 0;
    wsd_pkg::t_result pending_results[$];

    // Deframer state mirror.
    bit              srv_mode = 1'b1;
    wsd_pkg::t_phase parse_at = wsd_pkg::PH_HDR0;
    logic [3:0]      hdr_left = '0;
    logic [3:0]      cur_op = '0;
    bit              cur_fin = 1'b1;
    bit              cur_masked = 1'b0;
    bit              orphan = 1'b0;
    logic [31:0]     key_word = '0;
    logic [63:0]     pay_len = '0;
    logic [63:0]     pay_idx = '0;
    bit              frag_open = 1'b0;
    bit              frag_bin = 1'b0;
    bit              halted = 1'b0;

    websocket_frame_deframer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_data            (o_data),
        .o_frame_opcode    (o_frame_opcode),
        .o_is_binary       (o_is_binary),
        .o_frame_end       (o_frame_end),
        .o_message_end     (o_message_end),
        .o_stopped         (o_stopped),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_server_mode (i_cfg_server_mode)
    );

    always #4 i_clk = ~i_clk;

    function automatic wsd_pkg::t_result make_result(wsd_pkg::t_kind k, logic [7:0] d,
                                                     bit fend, bit mend, bit bin);
        return '{kind: k, data: d, frame_opcode: cur_op, is_binary: bin, frame_end: fend,
                 message_end: mend, stopped: halted};
    endfunction

    function automatic bit frame_bin();
        return cur_op == wsd_pkg::OP_BINARY
            || (cur_op == wsd_pkg::OP_CONT && !orphan && frag_bin);
    endfunction

    function automatic wsd_pkg::t_result frame_done(wsd_pkg::t_kind k, logic [7:0] d);
        bit bin;
        bit mend;
        bin = frame_bin();
        mend = cur_fin && (cur_op == wsd_pkg::OP_TEXT || cur_op == wsd_pkg::OP_BINARY ||
                           (cur_op == wsd_pkg::OP_CONT && !orphan));
        if (cur_op == wsd_pkg::OP_CLOSE) halted = 1'b1;
        parse_at = wsd_pkg::PH_HDR0;
        return make_result(k, d, 1'b1, mend, bin);
    endfunction

    function automatic bit start_payload(output wsd_pkg::t_result r);
        orphan = 1'b0;
        r = '0;
        if (cur_op == wsd_pkg::OP_TEXT || cur_op == wsd_pkg::OP_BINARY) begin
            frag_open = !cur_fin;
            if (!cur_fin) frag_bin = (cur_op == wsd_pkg::OP_BINARY);
        end else if (cur_op == wsd_pkg::OP_CONT) begin
            if (!frag_open) orphan = 1'b1;
            else if (cur_fin) frag_open = 1'b0;
        end
        pay_idx = '0;
        if (pay_len == 0) begin
            r = frame_done(orphan ? wsd_pkg::KIND_ORPHAN : wsd_pkg::KIND_EMPTY, 8'h00);
            return 1'b1;
        end
        parse_at = wsd_pkg::PH_PAY;
        return 1'b0;
    endfunction

    function automatic bit after_length(output wsd_pkg::t_result r);
        r = '0;
        if (cur_masked) begin
            hdr_left = 4'(wsd_pkg::MASK_KEY_BYTES);
            parse_at = wsd_pkg::PH_KEY;
            return 1'b0;
        end
        return start_payload(r);
    endfunction

    // Advance the mirror by one received byte; return 1 when it yields a result.
    function automatic bit deframe_byte(input logic [7:0] x, output wsd_pkg::t_result r);
        logic [7:0] kb;
        r = '0;
        if (halted) return 1'b0;
        case (parse_at)
            wsd_pkg::PH_HDR0: begin
                cur_fin = x[7];
                cur_op = x[3:0];
                orphan = 1'b0;
                parse_at = wsd_pkg::PH_HDR1;
                return 1'b0;
            end
            wsd_pkg::PH_HDR1: begin
                if (srv_mode && !x[7]) begin
                    halted = 1'b1;
                    r = make_result(wsd_pkg::KIND_UNMASKED, 8'h00, 1'b0, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (!(cur_op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY,
                                     wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING,
                                     wsd_pkg::OP_PONG})) begin
                    halted = 1'b1;
                    r = make_result(wsd_pkg::KIND_BAD_OP, 8'h00, 1'b0, 1'b0, 1'b0);
                    return 1'b1;
                end
                cur_masked = srv_mode;
                if (x[6:0] == wsd_pkg::LEN16_CODE || x[6:0] == wsd_pkg::LEN64_CODE) begin
                    pay_len = '0;
                    hdr_left = (x[6:0] == wsd_pkg::LEN16_CODE) ? wsd_pkg::LEN16_BYTES
                                                               : wsd_pkg::LEN64_BYTES;
                    parse_at = wsd_pkg::PH_EXT;
                    return 1'b0;
                end
                pay_len = 64'(x[6:0]);
                return after_length(r);
            end
            wsd_pkg::PH_EXT: begin
                pay_len = {pay_len[55:0], x};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left != 0) return 1'b0;
                return after_length(r);
            end
            wsd_pkg::PH_KEY: begin
                key_word = {key_word[23:0], x};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left != 0) return 1'b0;
                return start_payload(r);
            end
            wsd_pkg::PH_PAY: begin
                kb = cur_masked ? 8'(key_word >> (8 * (wsd_pkg::MASK_KEY_BYTES - 1 -
                                   int'(pay_idx % wsd_pkg::MASK_KEY_BYTES)))) : 8'h00;
                pay_idx = pay_idx + 64'd1;
                if (orphan) begin
                    if (pay_idx == pay_len) begin
                        r = frame_done(wsd_pkg::KIND_ORPHAN, 8'h00);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (pay_idx == pay_len) begin
                    r = frame_done(wsd_pkg::KIND_PAYLOAD, x ^ kb);
                    return 1'b1;
                end
                r = make_result(wsd_pkg::KIND_PAYLOAD, x ^ kb, 1'b0, 1'b0, frame_bin());
                return 1'b1;
            end
            default: begin
                parse_at = wsd_pkg::PH_HDR0;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name,
                                      got, want));
        end
    endtask

    // Sample both channels and the config port at the rising edge.
    always @(posedge i_clk) begin : scoreboard
        wsd_pkg::t_result pred;
        wsd_pkg::t_result want;
        bit               has;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                srv_mode = i_cfg_server_mode;
                cfg_taken++;
            end
            if (i_valid && !o_stall) begin
                has = deframe_byte(i_rx_byte, pred);
                if (row_typed) pending_results.insert(pending_results.size(), row_want);
                else if (has) pending_results.insert(pending_results.size(), pred);
                bytes_taken++;
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              results_seen));
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 8'(o_kind), 8'(want.kind));
                    check_field("data", o_data, want.data);
                    check_field("frame_opcode", 8'(o_frame_opcode), 8'(want.frame_opcode));
                    check_field("is_binary", 8'(o_is_binary), 8'(want.is_binary));
                    check_field("frame_end", 8'(o_frame_end), 8'(want.frame_end));
                    check_field("message_end", 8'(o_message_end), 8'(want.message_end));
                    check_field("stopped", 8'(o_stopped), 8'(want.stopped));
                end
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Present one beat, with random idle cycles ahead of it, and hold until taken.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input wsd_pkg::t_result want = '0);
        int unsigned seen;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        row_typed <= typed;
        row_want <= want;
        seen = bytes_taken;
        do @(negedge i_clk); while (bytes_taken == seen);
    endtask

    task automatic send_frame(input logic [3:0] op, input bit fin, input int unsigned len);
        logic [63:0] len64;
        bit          mbit;
        int unsigned pick;
        len64 = 64'(len);
        mbit = mode_now ? 1'b1 : 1'($urandom_range(1));
        pick = $urandom_range(99);
        send_byte({fin, 3'($urandom_range(7)), op});
        if (len > 125 || pick < 15) begin
            send_byte({mbit, wsd_pkg::LEN16_CODE});
            send_byte(len64[15:8]);
            send_byte(len64[7:0]);
        end else if (pick < 25) begin
            send_byte({mbit, wsd_pkg::LEN64_CODE});
            for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
        end else begin
            send_byte({mbit, 7'(len)});
        end
        if (mode_now) begin
            repeat (wsd_pkg::MASK_KEY_BYTES) send_byte(8'($urandom_range(255)));
        end
        repeat (len) send_byte(8'($urandom_range(255)));
    endtask

    // Drain, let header bytes still in flight settle, then write the mode.
    task automatic set_mode(input bit m);
        int unsigned seen;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_server_mode <= m;
        seen = cfg_taken;
        do @(negedge i_clk); while (cfg_taken == seen);
        i_cfg_valid <= 1'b0;
        mode_now = m;
    endtask

    initial begin
        int unsigned start;
        int unsigned pick;
        logic [3:0]  op;
        logic [3:0]  bad_op;
        bit          fin;
        int unsigned len;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(1'b1);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_byte(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_mode(ph % 2 == 1);
            steady = (ph == 2);
            start = bytes_taken;
            while (bytes_taken - start < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 28) op = wsd_pkg::OP_TEXT;
                else if (pick < 56) op = wsd_pkg::OP_BINARY;
                else if (pick < 78) op = wsd_pkg::OP_CONT;
                else if (pick < 89) op = wsd_pkg::OP_PING;
                else op = wsd_pkg::OP_PONG;
                if (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY) begin
                    fin = 1'($urandom_range(1));
                end else begin
                    fin = ($urandom_range(99) < 65);
                end
                len = ($urandom_range(99) < 4) ? $urandom_range(300, 126) : $urandom_range(12);
                send_frame(op, fin, len);
            end
        end
        steady = 1'b0;

        // One halting frame closes the run, then trailing bytes must be dropped.
        set_mode(1'($urandom_range(1)));
        pick = $urandom_range(2);
        if (pick == 0) begin
            send_frame(wsd_pkg::OP_CLOSE, 1'b1, $urandom_range(3));
        end else if (pick == 1 && mode_now) begin
            send_byte({1'b1, 3'b000, wsd_pkg::OP_TEXT});
            send_byte({1'b0, 7'($urandom_range(125))});
        end else begin
            do bad_op = 4'($urandom_range(15));
            while (bad_op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY,
                                  wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG});
            send_byte({1'($urandom_range(1)), 3'($urandom_range(7)), bad_op});
            send_byte({mode_now ? 1'b1 : 1'($urandom_range(1)), 7'($urandom_range(127))});
        end
        repeat (8) send_byte(8'($urandom_range(255)));
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/wsd_pkg.sv
design/wsd_parser.sv
design/websocket_frame_deframer.sv
design/wsd_checker.sv
verif/tb.sv
